// ===== rtl/core/can_motor_speed_pump_gateway_macros.svh =====
// assertion helpers for the gateway, sampled on clk and held off during reset
`ifndef CAN_MOTOR_SPEED_PUMP_GATEWAY_MACROS_SVH
`define CAN_MOTOR_SPEED_PUMP_GATEWAY_MACROS_SVH

// same-cycle implication
`define CMSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cmsp_pkg.sv =====
`timescale 1ns / 1ps

package cmsp_pkg;

    // elapsed counters and smoothing fixed point
    localparam int TIMER_W  = 17;
    localparam int SMOOTH_F = 16;

    // absolute motor speed, up to 16384
    localparam int SPEED_W  = 15;
    localparam int SMOOTH_W = SPEED_W + SMOOTH_F;

    localparam longint unsigned FIX_ONE = 64'd1 << SMOOTH_F;
    localparam longint unsigned ALPHA_Q = (15 * FIX_ONE + 50) / 100;
    localparam longint unsigned ALPHA_C = FIX_ONE - ALPHA_Q;
    localparam int ALPHA_W = SMOOTH_F + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_Q_V = ALPHA_W'(ALPHA_Q);
    localparam logic [ALPHA_W-1:0] ALPHA_C_V = ALPHA_W'(ALPHA_C);

    localparam int SPEED_CLAMP = 10000;
    localparam logic [SPEED_W-1:0] SPEED_CLAMP_V = SPEED_W'(SPEED_CLAMP);
    localparam logic [SMOOTH_W-1:0] SMOOTH_CLAMP_V =
        SMOOTH_W'(longint'(SPEED_CLAMP) << SMOOTH_F);

    // pump = 1 + floor(min(a, 10000) * 5999 / 10000), reciprocal exact for this range
    localparam int PUMP_SPAN = 5999;
    localparam int PUMP_X_W  = 26;
    localparam int PUMP_K    = 40;
    localparam longint unsigned PUMP_M = ((64'd1 << PUMP_K) + SPEED_CLAMP - 1) / SPEED_CLAMP;
    localparam int PUMP_M_W  = 27;
    localparam int PUMP_P_W  = PUMP_X_W + PUMP_M_W;

    // gauge = floor(floor(s * 9 / 2^F) / 500), reciprocal exact below 90001
    localparam int GAUGE_NUM = 180 / 20;
    localparam int GAUGE_DEN = SPEED_CLAMP / 20;
    localparam int GAUGE_T_W = 17;
    localparam int GAUGE_K   = 26;
    localparam longint unsigned GAUGE_M = ((64'd1 << GAUGE_K) + GAUGE_DEN - 1) / GAUGE_DEN;
    localparam int GAUGE_M_W = 18;
    localparam int GAUGE_P_W = GAUGE_T_W + GAUGE_M_W;

    // CAN identifiers and payload templates
    localparam logic [28:0] SPEED_RX_ID     = 29'h1DA;
    localparam logic [28:0] KEEPALIVE_TX_ID = 29'h1AE0092C;
    localparam logic [28:0] SPEED_TX_ID     = 29'h2104136;
    localparam logic [63:0] KEEPALIVE_BASE  = 64'h0000_22E0_4190_0000;
    localparam logic [63:0] SPEED_BASE      = 64'hBB00_3FFF_06E0_0000;
    localparam logic [3:0]  MIN_FRAME_LEN   = 4'd6;

    // queue sizes
    localparam int CMDQ_AW = 1;
    localparam int OUTQ_AW = 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK_TIMEOUT = 3'd0,
        REG_KA_PERIOD    = 3'd1,
        REG_SPEED_PERIOD = 3'd2,
        REG_IDLE_TIMEOUT = 3'd3,
        REG_DEADBAND     = 3'd4,
        REG_LED_LOW      = 3'd5,
        REG_LED_MID      = 3'd6,
        REG_IDLE_PUMP    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_INDICATOR = 2'd0,
        KIND_KEEPALIVE = 2'd1,
        KIND_SPEED     = 2'd2,
        KIND_FAULT     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_MUL,
        ST_F_ACC,
        ST_F_SCALE,
        ST_F_GAUGE,
        ST_F_EMIT,
        ST_T_CHECK,
        ST_T_KA,
        ST_T_SPD
    } state_t;

    typedef struct packed {
        logic [15:0] link_timeout;
        logic [15:0] ka_period;
        logic [15:0] speed_period;
        logic [15:0] idle_timeout;
        logic [13:0] deadband;
        logic [13:0] led_low;
        logic [13:0] led_mid;
        logic [12:0] idle_pump;
    } cfg_t;

    typedef struct packed {
        logic        is_tick;
        logic [15:0] raw;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [28:0] tx_id;
        logic [63:0] tx_data;
        logic [7:0]  gauge;
        logic [1:0]  leds;
        logic [12:0] pump;
        logic        pump_idle;
        logic        last;
    } result_t;

    typedef struct packed {
        logic link_active;
        logic busy;
    } stat_t;

endpackage

// ===== rtl/core/can_motor_speed_pump_gateway.sv =====
// speed frame: back end walks F_MUL, F_ACC, F_SCALE, F_GAUGE, then pushes the indicator beat in F_EMIT
// tick: T_CHECK ends with no result or a fault beat, or goes on to T_KA and T_SPD for one or two result beats
// input takes one beat per cycle while not full into a 2-entry command queue; the back end runs one item
// at a time, and each result push waits while the result queue is full.
// rst_n is asynchronous, active low: registers to defaults, link down, queues empty
`timescale 1ns / 1ps

module can_motor_speed_pump_gateway
(
    input  logic        clk,
    input  logic        rst_n,

    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [28:0] frame_id,
    input  logic        frame_extended,
    input  logic        frame_remote,
    input  logic [3:0]  frame_len,
    input  logic [7:0]  speed_byte_high,
    input  logic [7:0]  speed_byte_low,

    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [28:0] tx_id,
    output logic [63:0] tx_data,
    output logic [7:0]  gauge_angle,
    output logic [1:0]  led_count,
    output logic [12:0] pump_value,
    output logic        pump_idle,
    output logic        last,

    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import cmsp_pkg::*;

    `include "can_motor_speed_pump_gateway_macros.svh"

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    logic    res_full;
    logic    res_push;
    result_t res_beat;
    result_t head;
    stat_t   stat;
    logic    fault_push;

    // configuration registers, each truncated to its own width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_LINK_TIMEOUT: cfg_next.link_timeout = cfg_data;
                REG_KA_PERIOD:    cfg_next.ka_period    = cfg_data;
                REG_SPEED_PERIOD: cfg_next.speed_period = cfg_data;
                REG_IDLE_TIMEOUT: cfg_next.idle_timeout = cfg_data;
                REG_DEADBAND:     cfg_next.deadband     = cfg_data[13:0];
                REG_LED_LOW:      cfg_next.led_low      = cfg_data[13:0];
                REG_LED_MID:      cfg_next.led_mid      = cfg_data[13:0];
                REG_IDLE_PUMP:    cfg_next.idle_pump    = cfg_data[12:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_timeout <= 16'd2000;
            cfg_reg.ka_period    <= 16'd500;
            cfg_reg.speed_period <= 16'd14;
            cfg_reg.idle_timeout <= 16'd4000;
            cfg_reg.deadband     <= 14'd50;
            cfg_reg.led_low      <= 14'd3334;
            cfg_reg.led_mid      <= 14'd6667;
            cfg_reg.idle_pump    <= 13'd6000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: drops foreign frames, queues speed frames and ticks
    cmsp_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .frame_id        (frame_id),
        .frame_extended  (frame_extended),
        .frame_remote    (frame_remote),
        .frame_len       (frame_len),
        .speed_byte_high (speed_byte_high),
        .speed_byte_low  (speed_byte_low),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    // back: link state, timers, smoothing and frame building
    cmsp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_beat),
        .stat      (stat)
    );

    // result queue, decouples the back end from the consumer
    cmsp_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_beat),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (head)
    );

    assign result_kind = head.kind;
    assign tx_id       = head.tx_id;
    assign tx_data     = head.tx_data;
    assign gauge_angle = head.gauge;
    assign led_count   = head.leds;
    assign pump_value  = head.pump;
    assign pump_idle   = head.pump_idle;
    assign last        = head.last;

    // back end hands a fault beat to the result queue
    assign fault_push = res_push && (res_beat.kind == KIND_FAULT);

    // a fault beat always closes its tick
    `CMSP_ASSERT_NOW(a_fault_last, !empty && result_kind == KIND_FAULT, last, "fault beat not last")
    // link goes down only together with a fault beat
    `CMSP_ASSERT_NOW(a_link_drop, $fell(stat.link_active), $past(fault_push), "link drop, no fault")
    // back end never writes into a full result queue
    `CMSP_ASSERT_NOW(a_no_overrun, res_push, !res_full, "result queue overrun")

endmodule

// ===== rtl/core/cmsp_front.sv =====
`timescale 1ns / 1ps

module cmsp_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          req_type,
    input  logic [28:0]   frame_id,
    input  logic          frame_extended,
    input  logic          frame_remote,
    input  logic [3:0]    frame_len,
    input  logic [7:0]    speed_byte_high,
    input  logic [7:0]    speed_byte_low,
    output logic          cmd_valid,
    output cmsp_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import cmsp_pkg::*;

    localparam int DEPTH = 1 << CMDQ_AW;

    cmd_t               mem_reg [DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_next;
    logic [CMDQ_AW:0]   count_reg;
    logic [CMDQ_AW:0]   count_next;
    logic               frame_ok;
    logic               wr_en;
    logic               rd_en;

    // only speed frames and ticks go on; every other frame is dropped here
    assign frame_ok = !frame_extended && !frame_remote && (frame_id == SPEED_RX_ID)
                      && (frame_len >= MIN_FRAME_LEN);
    assign full     = (count_reg == (CMDQ_AW + 1)'(DEPTH));
    assign wr_en    = push && !full && (req_type || frame_ok);
    assign rd_en    = cmd_pop && cmd_valid;
    assign cmd_valid = (count_reg != '0);
    assign cmd      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= '{is_tick: req_type, raw: {speed_byte_high, speed_byte_low}};
        end
    end

endmodule

// ===== rtl/core/cmsp_outq.sv =====
`timescale 1ns / 1ps

module cmsp_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  cmsp_pkg::result_t res_in,
    output logic              res_full,
    output logic              empty,
    input  logic              pop,
    output cmsp_pkg::result_t res_out
);
    import cmsp_pkg::*;

    localparam int DEPTH = 1 << OUTQ_AW;

    result_t            mem_reg [DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg;
    logic [OUTQ_AW-1:0] wr_ptr_next;
    logic [OUTQ_AW-1:0] rd_ptr_reg;
    logic [OUTQ_AW-1:0] rd_ptr_next;
    logic [OUTQ_AW:0]   count_reg;
    logic [OUTQ_AW:0]   count_next;
    logic               wr_en;
    logic               rd_en;

    assign res_full = (count_reg == (OUTQ_AW + 1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;
    assign res_out  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ===== rtl/core/cmsp_back.sv =====
`timescale 1ns / 1ps

module cmsp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmsp_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    input  cmsp_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output cmsp_pkg::result_t res,
    output cmsp_pkg::stat_t   stat
);
    import cmsp_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic                 link_reg;
    logic                 link_next;
    logic [SPEED_W-1:0]   speed_reg;
    logic [SPEED_W-1:0]   speed_next;
    logic [SMOOTH_W-1:0]  smooth_reg;
    logic [SMOOTH_W-1:0]  smooth_next;
    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;
    logic [TIMER_W-1:0]   frame_ms_reg;
    logic [TIMER_W-1:0]   frame_ms_next;
    logic [TIMER_W-1:0]   motion_ms_reg;
    logic [TIMER_W-1:0]   motion_ms_next;
    logic [TIMER_W-1:0]   ka_ms_reg;
    logic [TIMER_W-1:0]   ka_ms_next;
    logic [TIMER_W-1:0]   sp_ms_reg;
    logic [TIMER_W-1:0]   sp_ms_next;

    // datapath registers
    logic [1:0]                  leds_reg;
    logic [ALPHA_W+SPEED_W-1:0]  p1_reg;
    logic [ALPHA_W+SMOOTH_W-1:0] p2_reg;
    logic [PUMP_X_W-1:0]         pump_x_reg;
    logic [12:0]                 pump_lin_reg;
    logic [GAUGE_T_W-1:0]        gauge_t_reg;
    logic [7:0]                  gauge_reg;

    logic signed [15:0]   raw_s;
    logic signed [15:0]   half_s;
    logic [SPEED_W-1:0]   frame_abs;
    logic [1:0]           frame_leds;
    logic [SPEED_W-1:0]   speed_cl;
    logic [SMOOTH_W-1:0]  smooth_acc;
    logic [SMOOTH_W-1:0]  smooth_cl;
    logic [PUMP_P_W-1:0]  pump_prod;
    logic [GAUGE_P_W-1:0] gauge_prod;
    logic [SMOOTH_W+3:0]  scaled;
    logic                 timeout;
    logic                 ka_due;
    logic                 sp_due;
    logic                 idle_sel;

    // speed is raw / 2 rounded toward zero
    always_comb
    begin
        raw_s  = signed'(cmd.raw);
        half_s = raw_s >>> 1;
        if (raw_s[15] && raw_s[0])
        begin
            half_s = half_s + 16'sd1;
        end
        frame_abs = half_s[15] ? SPEED_W'(-half_s) : SPEED_W'(half_s);
        if (frame_abs < SPEED_W'(cfg.led_low))
        begin
            frame_leds = 2'd3;
        end
        else if (frame_abs < SPEED_W'(cfg.led_mid))
        begin
            frame_leds = 2'd2;
        end
        else
        begin
            frame_leds = 2'd1;
        end
    end

    assign speed_cl   = (speed_reg > SPEED_CLAMP_V) ? SPEED_CLAMP_V : speed_reg;
    assign smooth_acc = SMOOTH_W'(p1_reg + (p2_reg >> SMOOTH_F));
    assign smooth_cl  = (smooth_reg > SMOOTH_CLAMP_V) ? SMOOTH_CLAMP_V : smooth_reg;
    assign pump_prod  = PUMP_P_W'(pump_x_reg) * PUMP_P_W'(PUMP_M);
    assign scaled     = (SMOOTH_W + 4)'(smooth_cl) * (SMOOTH_W + 4)'(GAUGE_NUM);
    assign gauge_prod = GAUGE_P_W'(gauge_t_reg) * GAUGE_P_W'(GAUGE_M);

    assign timeout  = 32'(frame_ms_reg) > 32'(cfg.link_timeout);
    assign ka_due   = 32'(ka_ms_reg) >= 32'(cfg.ka_period);
    assign sp_due   = 32'(sp_ms_reg) >= 32'(cfg.speed_period);
    assign idle_sel = 32'(motion_ms_reg) > 32'(cfg.idle_timeout);

    always_comb
    begin
        state_next     = state_reg;
        link_next      = link_reg;
        speed_next     = speed_reg;
        smooth_next    = smooth_reg;
        phase_next     = phase_reg;
        frame_ms_next  = frame_ms_reg;
        motion_ms_next = motion_ms_reg;
        ka_ms_next     = ka_ms_reg;
        sp_ms_next     = sp_ms_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_tick)
                    begin
                        frame_ms_next  = (&frame_ms_reg) ? frame_ms_reg : frame_ms_reg + 1'b1;
                        motion_ms_next = (&motion_ms_reg) ? motion_ms_reg
                                                          : motion_ms_reg + 1'b1;
                        ka_ms_next     = (&ka_ms_reg) ? ka_ms_reg : ka_ms_reg + 1'b1;
                        sp_ms_next     = (&sp_ms_reg) ? sp_ms_reg : sp_ms_reg + 1'b1;
                        state_next     = ST_T_CHECK;
                    end
                    else
                    begin
                        frame_ms_next = '0;
                        link_next     = 1'b1;
                        speed_next    = frame_abs;
                        if (frame_abs > SPEED_W'(cfg.deadband))
                        begin
                            motion_ms_next = '0;
                        end
                        state_next = ST_F_MUL;
                    end
                end
            end
            ST_F_MUL:
            begin
                state_next = ST_F_ACC;
            end
            ST_F_ACC:
            begin
                smooth_next = smooth_acc;
                state_next  = ST_F_SCALE;
            end
            ST_F_SCALE:
            begin
                state_next = ST_F_GAUGE;
            end
            ST_F_GAUGE:
            begin
                state_next = ST_F_EMIT;
            end
            ST_F_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res.kind   = KIND_INDICATOR;
                    res.gauge  = gauge_reg;
                    res.leds   = leds_reg;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_T_CHECK:
            begin
                if (!link_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (timeout)
                begin
                    if (!res_full)
                    begin
                        res_push    = 1'b1;
                        res.kind    = KIND_FAULT;
                        res.last    = 1'b1;
                        link_next   = 1'b0;
                        speed_next  = '0;
                        smooth_next = '0;
                        state_next  = ST_IDLE;
                    end
                end
                else if (ka_due)
                begin
                    state_next = ST_T_KA;
                end
                else if (sp_due)
                begin
                    state_next = ST_T_SPD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_T_KA:
            begin
                if (!res_full)
                begin
                    res_push    = 1'b1;
                    res.kind    = KIND_KEEPALIVE;
                    res.tx_id   = KEEPALIVE_TX_ID;
                    res.tx_data = KEEPALIVE_BASE | {phase_reg, 62'd0};
                    res.last    = !sp_due;
                    phase_next  = phase_reg + 1'b1;
                    ka_ms_next  = '0;
                    state_next  = sp_due ? ST_T_SPD : ST_IDLE;
                end
            end
            ST_T_SPD:
            begin
                if (!res_full)
                begin
                    res_push      = 1'b1;
                    res.kind      = KIND_SPEED;
                    res.tx_id     = SPEED_TX_ID;
                    res.pump      = idle_sel ? cfg.idle_pump : pump_lin_reg;
                    res.pump_idle = idle_sel;
                    res.tx_data   = SPEED_BASE | 64'(res.pump);
                    res.last      = 1'b1;
                    sp_ms_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat = '{link_active: link_reg, busy: (state_reg != ST_IDLE)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            link_reg      <= 1'b0;
            speed_reg     <= '0;
            smooth_reg    <= '0;
            phase_reg     <= '0;
            frame_ms_reg  <= '0;
            motion_ms_reg <= '1;
            ka_ms_reg     <= '1;
            sp_ms_reg     <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            link_reg      <= link_next;
            speed_reg     <= speed_next;
            smooth_reg    <= smooth_next;
            phase_reg     <= phase_next;
            frame_ms_reg  <= frame_ms_next;
            motion_ms_reg <= motion_ms_next;
            ka_ms_reg     <= ka_ms_next;
            sp_ms_reg     <= sp_ms_next;
        end
    end

    // frame arithmetic, one multiply level per step
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid && !cmd.is_tick)
        begin
            leds_reg <= frame_leds;
        end
        if (state_reg == ST_F_MUL)
        begin
            p1_reg     <= (ALPHA_W + SPEED_W)'(ALPHA_Q_V) * (ALPHA_W + SPEED_W)'(speed_reg);
            p2_reg     <= (ALPHA_W + SMOOTH_W)'(ALPHA_C_V) * (ALPHA_W + SMOOTH_W)'(smooth_reg);
            pump_x_reg <= PUMP_X_W'(speed_cl) * PUMP_X_W'(PUMP_SPAN);
        end
        if (state_reg == ST_F_ACC)
        begin
            pump_lin_reg <= 13'(pump_prod >> PUMP_K) + 13'd1;
        end
        if (state_reg == ST_F_SCALE)
        begin
            gauge_t_reg <= GAUGE_T_W'(scaled >> SMOOTH_F);
        end
        if (state_reg == ST_F_GAUGE)
        begin
            gauge_reg <= 8'(gauge_prod >> GAUGE_K);
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cmsp_pkg::*;

    // one input beat as the sender presents it
    typedef struct {
        logic        tick;
        logic [28:0] id;
        logic        ext;
        logic        rtr;
        logic [3:0]  len;
        logic [7:0]  hi;
        logic [7:0]  lo;
    } gw_req_t;

    // one value per register, in register index order
    typedef logic [15:0] reg_set_t [8];

    // elapsed counters stick at all ones
    localparam logic [16:0] MS_SAT = 17'h1FFFF;
    // smoothing in q16, alpha rounded from 0.15
    localparam longint unsigned Q_ONE = 64'd1 << 16;
    localparam longint unsigned Q_ALPHA = (15 * Q_ONE + 50) / 100;
    // speed clamp in q16, full deflection of the gauge
    localparam longint unsigned FULL_SCALE = 64'd10000 << 16;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        req_type;
    logic [28:0] frame_id;
    logic        frame_extended;
    logic        frame_remote;
    logic [3:0]  frame_len;
    logic [7:0]  speed_byte_high;
    logic [7:0]  speed_byte_low;
    logic        empty;
    logic        pop;
    logic [1:0]  result_kind;
    logic [28:0] tx_id;
    logic [63:0] tx_data;
    logic [7:0]  gauge_angle;
    logic [1:0]  led_count;
    logic [12:0] pump_value;
    logic        pump_idle;
    logic        last;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // gateway state as the bench tracks it
    logic            link_up;
    int              spd_now;
    longint unsigned spd_avg;
    logic [1:0]      ka_seq;
    logic [16:0]     ms_rx;
    logic [16:0]     ms_moving;
    logic [16:0]     ms_ka;
    logic [16:0]     ms_pump;
    logic [15:0]     reg_val [8];

    // result beats owed by the gateway, oldest first
    result_t due_results [$];

    int n_mismatch = 0;
    int n_beats    = 0;

    // idle draw limits for each side, and a one-shot long receiver hold-off
    int tx_gap_max = 12;
    int rx_gap_max = 12;
    int rx_hold    = 0;

    can_motor_speed_pump_gateway u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .frame_id        (frame_id),
        .frame_extended  (frame_extended),
        .frame_remote    (frame_remote),
        .frame_len       (frame_len),
        .speed_byte_high (speed_byte_high),
        .speed_byte_low  (speed_byte_low),
        .empty           (empty),
        .pop             (pop),
        .result_kind     (result_kind),
        .tx_id           (tx_id),
        .tx_data         (tx_data),
        .gauge_angle     (gauge_angle),
        .led_count       (led_count),
        .pump_value      (pump_value),
        .pump_idle       (pump_idle),
        .last            (last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 250 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // gateway behavior
    // ---------------------------------------------------------------

    function automatic logic [15:0] reg_mask(cfg_idx_t idx);
        case (idx)
            REG_DEADBAND, REG_LED_LOW, REG_LED_MID: return 16'h3FFF;
            REG_IDLE_PUMP: return 16'h1FFF;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [16:0] ms_step(logic [16:0] v);
        return (v == MS_SAT) ? MS_SAT : v + 17'd1;
    endfunction

    function automatic void clear_gateway();
        link_up   = 1'b0;
        spd_now   = 0;
        spd_avg   = 0;
        ka_seq    = 2'd0;
        ms_rx     = '0;
        ms_moving = MS_SAT;
        ms_ka     = MS_SAT;
        ms_pump   = MS_SAT;
        reg_val[REG_LINK_TIMEOUT] = 16'd2000;
        reg_val[REG_KA_PERIOD]    = 16'd500;
        reg_val[REG_SPEED_PERIOD] = 16'd14;
        reg_val[REG_IDLE_TIMEOUT] = 16'd4000;
        reg_val[REG_DEADBAND]     = 16'd50;
        reg_val[REG_LED_LOW]      = 16'd3334;
        reg_val[REG_LED_MID]      = 16'd6667;
        reg_val[REG_IDLE_PUMP]    = 16'd6000;
    endfunction

    function automatic result_t blank_result(kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    // results of one accepted beat; advances the tracked state
    function automatic void gateway_response(gw_req_t q);
        result_t         batch [$];
        result_t         r;
        int              raw;
        longint unsigned mag;
        longint unsigned clipped;
        logic            quiet;
        if (!q.tick)
        begin
            // only standard data frames with the speed id and six bytes or more count
            if (q.rtr || q.ext || q.id != SPEED_RX_ID || q.len < 4'd6)
                return;
            raw = $signed({q.hi, q.lo});
            spd_now = raw / 2;
            ms_rx = '0;
            link_up = 1'b1;
            mag = (spd_now < 0) ? -spd_now : spd_now;
            if (mag > reg_val[REG_DEADBAND])
                ms_moving = '0;
            spd_avg = (Q_ALPHA * (mag << 16) + (Q_ONE - Q_ALPHA) * spd_avg) >> 16;
            clipped = (spd_avg > FULL_SCALE) ? FULL_SCALE : spd_avg;
            r = blank_result(KIND_INDICATOR);
            r.gauge = 8'(clipped * 180 / FULL_SCALE);
            r.leds = (mag < reg_val[REG_LED_LOW]) ? 2'd3 :
                     (mag < reg_val[REG_LED_MID]) ? 2'd2 : 2'd1;
            batch.push_back(r);
        end
        else
        begin
            ms_rx     = ms_step(ms_rx);
            ms_moving = ms_step(ms_moving);
            ms_ka     = ms_step(ms_ka);
            ms_pump   = ms_step(ms_pump);
            if (link_up && ms_rx > reg_val[REG_LINK_TIMEOUT])
            begin
                link_up = 1'b0;
                spd_now = 0;
                spd_avg = 0;
                batch.push_back(blank_result(KIND_FAULT));
            end
            if (link_up)
            begin
                if (ms_ka >= reg_val[REG_KA_PERIOD])
                begin
                    r = blank_result(KIND_KEEPALIVE);
                    r.tx_id = KEEPALIVE_TX_ID;
                    r.tx_data = KEEPALIVE_BASE | {ka_seq, 62'd0};
                    batch.push_back(r);
                    ka_seq = ka_seq + 2'd1;
                    ms_ka = '0;
                end
                if (ms_pump >= reg_val[REG_SPEED_PERIOD])
                begin
                    quiet = ms_moving > reg_val[REG_IDLE_TIMEOUT];
                    mag = (spd_now < 0) ? -spd_now : spd_now;
                    clipped = (mag > 10000) ? 10000 : mag;
                    r = blank_result(KIND_SPEED);
                    r.tx_id = SPEED_TX_ID;
                    r.pump = quiet ? reg_val[REG_IDLE_PUMP][12:0] :
                                     13'(1 + clipped * 5999 / 10000);
                    r.tx_data = SPEED_BASE | 64'(r.pump);
                    r.pump_idle = quiet;
                    batch.push_back(r);
                    ms_pump = '0;
                end
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            due_results.push_back(batch[i]);
    endfunction

    // ---------------------------------------------------------------
    // beat builders
    // ---------------------------------------------------------------

    function automatic gw_req_t speed_req(logic [15:0] raw);
        gw_req_t q;
        q.tick = 1'b0;
        q.id   = SPEED_RX_ID;
        q.ext  = 1'b0;
        q.rtr  = 1'b0;
        // lengths past eight count as long enough
        q.len  = 4'($urandom_range(15, 6));
        q.hi   = raw[15:8];
        q.lo   = raw[7:0];
        return q;
    endfunction

    // frame fields are junk on a tick and must not matter
    function automatic gw_req_t tick_req();
        gw_req_t q;
        q = speed_req(16'($urandom()));
        q.tick = 1'b1;
        q.id   = 29'($urandom());
        q.ext  = 1'($urandom());
        q.rtr  = 1'($urandom());
        q.len  = 4'($urandom());
        return q;
    endfunction

    // frames the gateway must drop: one flaw each, or random traffic on other ids
    function automatic gw_req_t noise_req();
        gw_req_t q;
        q = speed_req(16'($urandom()));
        case ($urandom_range(3))
            0: q.ext = 1'b1;
            1: q.rtr = 1'b1;
            2: q.len = 4'($urandom_range(5));
            default:
            begin
                q.id  = 29'($urandom());
                q.ext = 1'($urandom());
                q.rtr = 1'($urandom());
                q.len = 4'($urandom());
            end
        endcase
        return q;
    endfunction

    function automatic logic [15:0] rand_raw();
        logic [15:0] raw;
        int          pick;
        pick = $urandom_range(19);
        if (pick < 2)
        begin
            case ($urandom_range(5))
                0: raw = 16'h7FFF;
                1: raw = 16'h8000;
                2: raw = 16'hFFFF;
                3: raw = 16'h0001;
                4: raw = 16'h0000;
                default: raw = 16'h8001;
            endcase
        end
        else if (pick < 5)
        begin
            // right around the clamp speed
            raw = 16'(19996 + $urandom_range(8));
            if ($urandom_range(1))
                raw = -raw;
        end
        else
            raw = 16'($urandom());
        return raw;
    endfunction

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------

    // entered and left on a rising edge; predicts once the beat is taken
    task automatic send_req(gw_req_t q);
        int gap;
        gap = $urandom_range(tx_gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push            <= 1'b1;
        req_type        <= q.tick;
        frame_id        <= q.id;
        frame_extended  <= q.ext;
        frame_remote    <= q.rtr;
        frame_len       <= q.len;
        speed_byte_high <= q.hi;
        speed_byte_low  <= q.lo;
        // inputs and outputs only move on rising edges, so the falling edge sees
        // what the next rising edge will act on
        do @(negedge clk); while (full);
        @(posedge clk);
        gateway_response(q);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on beat %0d: %s is %0h, %0h due", n_beats, what, got, want);
        n_mismatch++;
    endtask

    task automatic check_beat();
        result_t want;
        n_beats++;
        if (due_results.size() == 0)
        begin
            report_mismatch("beat with nothing due, kind", result_kind, 0);
            return;
        end
        want = due_results.pop_front();
        if (result_kind !== want.kind)
            report_mismatch("result_kind", result_kind, want.kind);
        if (tx_id !== want.tx_id)
            report_mismatch("tx_id", tx_id, want.tx_id);
        if (tx_data !== want.tx_data)
            report_mismatch("tx_data", tx_data, want.tx_data);
        if (gauge_angle !== want.gauge)
            report_mismatch("gauge_angle", gauge_angle, want.gauge);
        if (led_count !== want.leds)
            report_mismatch("led_count", led_count, want.leds);
        if (pump_value !== want.pump)
            report_mismatch("pump_value", pump_value, want.pump);
        if (pump_idle !== want.pump_idle)
            report_mismatch("pump_idle", pump_idle, want.pump_idle);
        if (last !== want.last)
            report_mismatch("last", last, want.last);
    endtask

    // result side: a beat is taken at the rising edge after a falling edge
    // that sees pop high and empty low
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && pop && !empty)
            check_beat();
    end

    // result side pacing: random stalls, plus the long hold-off when asked
    initial
    begin : rx_side
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                pop <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = $urandom_range(rx_gap_max);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(negedge clk); while (empty);
            @(posedge clk);
        end
    end

    // ---------------------------------------------------------------
    // phase control
    // ---------------------------------------------------------------

    // wait for every owed beat, then cover a trailing frame or tick that owes none
    task automatic settle();
        push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // only while idle; all eight registers every time
    task automatic apply_settings(reg_set_t regs);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= regs[i];
            @(posedge clk);
            reg_val[i] = regs[i] & reg_mask(cfg_idx_t'(i));
        end
        cfg_we <= 1'b0;
    endtask

    // mostly speed frames and tick runs, some dropped frames in between
    task automatic run_mixed(int n_items);
        int          sent;
        int          pick;
        int          run;
        int          v;
        logic [15:0] raw;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                send_req(speed_req(rand_raw()));
                run = $urandom_range(4);
                sent += run + 1;
                repeat (run) send_req(tick_req());
            end
            else if (pick < 63)
            begin
                // bus goes quiet, long enough to lose the link at small timeouts
                run = $urandom_range(45, 1);
                sent += run;
                repeat (run) send_req(tick_req());
            end
            else if (pick < 78)
            begin
                // crawl speeds around the deadband, so the idle timer can run out
                v = $urandom_range(int'(reg_val[REG_DEADBAND]) + 3);
                raw = 16'(2 * v + $urandom_range(1));
                if ($urandom_range(1))
                    raw = -raw;
                send_req(speed_req(raw));
                run = $urandom_range(6);
                sent += run + 1;
                repeat (run) send_req(tick_req());
            end
            else
                send_req(noise_req());
        end
    endtask

    task automatic run_segment(reg_set_t regs, int n_items, int tx_max, int rx_max);
        settle();
        apply_settings(regs);
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        run_mixed(n_items);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset registers; timers but the frame timer start saturated, link down
    task automatic test_after_reset();
        // link down: a tick only advances the timers
        send_req(tick_req());
        send_req(speed_req(16'h1000));
        // keep-alive and pump timers were saturated, both frames leave on this tick
        send_req(tick_req());
        send_req(tick_req());
    endtask

    // frame acceptance rules and raw speed extremes
    task automatic test_frame_filter();
        gw_req_t q;
        q = speed_req(16'h4000);
        q.id = SPEED_RX_ID ^ 29'h1;
        send_req(q);
        q = speed_req(16'h4000);
        q.ext = 1'b1;
        send_req(q);
        q = speed_req(16'h4000);
        q.rtr = 1'b1;
        send_req(q);
        q = speed_req(16'h4000);
        q.len = 4'd5;
        send_req(q);
        // most negative raw speed, with a length beyond eight
        q = speed_req(16'h8000);
        q.len = 4'd15;
        send_req(q);
        q = speed_req(16'h7FFF);
        q.len = 4'd8;
        send_req(q);
        // minus one and plus one both halve to zero
        q = speed_req(16'hFFFF);
        q.len = 4'd6;
        send_req(q);
        q = speed_req(16'h0001);
        q.len = 4'd9;
        send_req(q);
        send_req(tick_req());
    endtask

    // link loss on ticks, relink by a frame, idle pump choice
    task automatic test_link_loss();
        reg_set_t regs;
        regs = '{16'd4, 16'd3, 16'd2, 16'd3, 16'd100, 16'd3334, 16'd6667, 16'd777};
        apply_settings(regs);
        send_req(speed_req(16'd10000));
        // fifth tick runs past the timeout and clears the link
        repeat (6) send_req(tick_req());
        // a frame after a long silence just relinks, no fault from a frame
        send_req(speed_req(16'd120));
        // speed inside the deadband, so the pump value goes idle
        repeat (3) send_req(tick_req());
    endtask

    // hold the result side off long enough that the input side backs up
    task automatic test_backpressure();
        reg_set_t regs;
        regs = '{16'd60000, 16'd1, 16'd1, 16'd30000, 16'd50, 16'd3334, 16'd6667, 16'd6000};
        apply_settings(regs);
        tx_gap_max = 0;
        rx_hold = 400;
        send_req(speed_req(16'd9000));
        // every tick owes a keep-alive and a pump frame
        repeat (40) send_req(tick_req());
        tx_gap_max = 12;
    endtask

    // random traffic under small, extreme and random register settings
    task automatic test_random_traffic();
        reg_set_t regs;
        regs = '{16'd25, 16'd7, 16'd3, 16'd12, 16'd120, 16'd3334, 16'd6667, 16'd4321};
        run_segment(regs, 330, 12, 12);
        // lowest settings, no idling on either side
        regs = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1};
        run_segment(regs, 200, 0, 0);
        // highest settings
        regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'd10000, 16'd10000, 16'd10000, 16'd6000};
        run_segment(regs, 120, 12, 3);
        repeat (4)
        begin
            regs[REG_LINK_TIMEOUT] = 16'($urandom_range(40, 2));
            regs[REG_KA_PERIOD]    = 16'($urandom_range(10, 1));
            regs[REG_SPEED_PERIOD] = 16'($urandom_range(6, 1));
            regs[REG_IDLE_TIMEOUT] = 16'($urandom_range(30, 1));
            regs[REG_DEADBAND]     = 16'($urandom_range(300));
            // thresholds may come out crossed, which the block must take as given
            regs[REG_LED_LOW]      = 16'($urandom_range(10000));
            regs[REG_LED_MID]      = 16'($urandom_range(10000));
            regs[REG_IDLE_PUMP]    = 16'($urandom_range(6000, 1));
            run_segment(regs, 250, $urandom_range(12), 12);
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin : main_seq
        push            <= 1'b0;
        req_type        <= 1'b0;
        frame_id        <= '0;
        frame_extended  <= 1'b0;
        frame_remote    <= 1'b0;
        frame_len       <= '0;
        speed_byte_high <= '0;
        speed_byte_low  <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_LINK_TIMEOUT;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        clear_gateway();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        settle();
        test_frame_filter();
        settle();
        test_link_loss();
        settle();
        test_backpressure();
        settle();
        test_random_traffic();
        settle();

        if (n_mismatch == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin : watchdog
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
